// File: sv/pwc_pkg.sv
// Shared types and constants for the packet worker classifier.
package pwc_pkg;
  localparam int MaxMplsLabels = 8;
  localparam int LblW = $clog2(MaxMplsLabels + 1);

  localparam logic [15:0] EtMpls   = 16'h8847;
  localparam logic [15:0] Et8021ad = 16'h88A8;
  localparam logic [15:0] EtIpv4   = 16'h0800;
  localparam logic [15:0] EtIpv6   = 16'h86DD;
  localparam logic [15:0] EtLldp   = 16'h88CC;
  localparam logic [15:0] EtVlan   = 16'h8100;
  localparam logic [7:0]  ProtoGre = 8'd47;
  localparam logic [7:0]  ProtoUdp = 8'd17;
  localparam logic [27:0] GreKeyMask = 28'hFFFFFFF;

  localparam logic [1:0] AddrWorkerCount = 2'd0;
  localparam logic [1:0] AddrQinqEt      = 2'd1;
  localparam logic [1:0] AddrIpv6Off     = 2'd2;
  localparam logic [1:0] AddrStripEn     = 2'd3;

  // Job handed from the parser to the worker selector.
  typedef struct packed {
    logic        drop;
    logic        ipv6;
    logic [31:0] key;
    logic [LblW-1:0] labels;
  } job_t;

  localparam int QDepth = 2;
endpackage

// File: sv/pwc_parser.sv
// Front end: byte-serial header parser, one job per packet.
module pwc_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data_byte,
  input  logic                in_last_byte,
  input  logic [15:0]         qinq_ethertype,
  input  logic [5:0]          ipv6_key_byte_offset,
  output logic                job_valid,
  input  logic                job_ready,
  output pwc_pkg::job_t       job
);
  import pwc_pkg::*;

  typedef enum logic [3:0] {
    PH_ETH, PH_MPLS, PH_MPLS_BOS, PH_L3, PH_IP4, PH_IP4_UDP, PH_IP4_GRE,
    PH_IP6, PH_QINQ, PH_DONE
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [15:0]     pos_r;
  logic [LblW-1:0] lbl_r, lbl_nxt;
  logic [31:0]     shift_r, shift_nxt;
  logic [15:0]     gre_r, gre_nxt;
  logic            ok_r, ok_nxt;
  logic            v6_r, v6_nxt;
  logic [31:0]     key_r, key_nxt;

  logic [15:0] base, rel;
  logic [7:0]  b;
  phase_t      ph;
  logic [5:0]  off;
  logic [15:0] sh16;
  logic [31:0] sh32;
  logic [15:0] g16;
  logic        acc;

  assign b = in_data_byte;
  assign in_ready = job_ready;
  assign acc = in_valid && in_ready;
  assign base = 16'd14 + {{(14 - LblW){1'b0}}, lbl_r, 2'b00};
  assign rel = (pos_r >= base) ? pos_r - base : 16'd0;
  assign sh16 = {shift_r[7:0], b};
  assign sh32 = {shift_r[23:0], b};
  assign g16 = {gre_r[7:0], b};

  always_comb begin
    phase_nxt = phase_r;
    lbl_nxt = lbl_r;
    shift_nxt = shift_r;
    gre_nxt = gre_r;
    ok_nxt = ok_r;
    v6_nxt = v6_r;
    key_nxt = key_r;
    off = (gre_r[15:14] != 2'b00) ? 6'd28 : 6'd24;
    ph = phase_r;
    if (phase_r == PH_L3) begin
      if (b[7:4] == 4'd4) ph = PH_IP4;
      else if (b[7:4] == 4'd6) ph = PH_IP6;
      else ph = PH_DONE;
      phase_nxt = ph;
    end
    if (phase_r != PH_L3 || ph != PH_DONE) begin
      case (ph)
        PH_ETH: begin
          if (pos_r == 16'd12 || pos_r == 16'd13) shift_nxt = {16'd0, sh16};
          if (pos_r == 16'd13) begin
            if (sh16 == EtMpls) phase_nxt = PH_MPLS;
            else if (sh16 == Et8021ad) phase_nxt = PH_QINQ;
            else if (sh16 == EtIpv4) phase_nxt = PH_IP4;
            else if (sh16 == EtIpv6) phase_nxt = PH_IP6;
            else if (sh16 == EtLldp) phase_nxt = PH_DONE;
            else if (sh16 == qinq_ethertype) phase_nxt = PH_QINQ;
            else phase_nxt = PH_DONE;
          end
        end
        PH_MPLS: begin
          if (pos_r[1:0] == 2'd0 && b[0]) phase_nxt = PH_MPLS_BOS;
          else if (pos_r[1:0] == 2'd1) begin
            lbl_nxt = lbl_r + 1'b1;
            if (lbl_nxt >= LblW'(MaxMplsLabels)) phase_nxt = PH_DONE;
          end
        end
        PH_MPLS_BOS: begin
          lbl_nxt = lbl_r + 1'b1;
          phase_nxt = PH_L3;
        end
        PH_IP4: begin
          if (rel == 16'd0 && b[7:4] != 4'd4) phase_nxt = PH_DONE;
          else if (rel == 16'd9) begin
            if (b == ProtoGre) begin
              phase_nxt = PH_IP4_GRE;
              gre_nxt = 16'd0;
            end else if (b == ProtoUdp) phase_nxt = PH_IP4_UDP;
            else phase_nxt = PH_DONE;
          end
        end
        PH_IP4_UDP: begin
          if (rel >= 16'd16 && rel <= 16'd19) shift_nxt = sh32;
          if (rel == 16'd19) begin
            phase_nxt = PH_DONE; ok_nxt = 1'b1; v6_nxt = 1'b0; key_nxt = sh32;
          end
        end
        PH_IP4_GRE: begin
          if (rel == 16'd20 || rel == 16'd21) begin
            gre_nxt = g16;
            if (rel == 16'd21 && !g16[13]) phase_nxt = PH_DONE;
          end else if (rel >= 16'd22) begin
            if (rel >= {10'd0, off} && rel <= {10'd0, off} + 16'd3) shift_nxt = sh32;
            if (rel == {10'd0, off} + 16'd3) begin
              phase_nxt = PH_DONE; ok_nxt = 1'b1; v6_nxt = 1'b0;
              key_nxt = {4'd0, sh32[27:0] & GreKeyMask};
            end
          end
        end
        PH_IP6: begin
          if (rel == 16'd0 && b[7:4] != 4'd6) phase_nxt = PH_DONE;
          else if (rel == {10'd0, ipv6_key_byte_offset}) begin
            phase_nxt = PH_DONE; ok_nxt = 1'b1; v6_nxt = 1'b1; key_nxt = {24'd0, b};
          end
        end
        PH_QINQ: begin
          if (pos_r >= 16'd16 && pos_r <= 16'd19) shift_nxt = {16'd0, sh16};
          if (pos_r == 16'd17 && sh16 != EtVlan) phase_nxt = PH_DONE;
          else if (pos_r == 16'd19) begin
            phase_nxt = PH_DONE; ok_nxt = 1'b1; v6_nxt = 1'b0;
            key_nxt = {20'd0, sh16[11:0]};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ETH;
      pos_r <= 16'd0;
      lbl_r <= '0;
      shift_r <= 32'd0;
      gre_r <= 16'd0;
      ok_r <= 1'b0;
      v6_r <= 1'b0;
      key_r <= 32'd0;
    end else if (acc) begin
      if (in_last_byte) begin
        phase_r <= PH_ETH;
        pos_r <= 16'd0;
        lbl_r <= '0;
        shift_r <= 32'd0;
        gre_r <= 16'd0;
        ok_r <= 1'b0;
      end else begin
        if (phase_r != PH_DONE) begin
          phase_r <= phase_nxt;
          lbl_r <= lbl_nxt;
          shift_r <= shift_nxt;
          gre_r <= gre_nxt;
          ok_r <= ok_nxt;
          v6_r <= v6_nxt;
          key_r <= key_nxt;
        end
        if (pos_r != 16'hFFFF) pos_r <= pos_r + 16'd1;
      end
    end
  end

  logic fin_ok, fin_v6;
  logic [31:0] fin_key;
  logic [LblW-1:0] fin_lbl;
  always_comb begin
    if (phase_r != PH_DONE) begin
      fin_ok = ok_nxt && (phase_nxt == PH_DONE);
      fin_v6 = v6_nxt;
      fin_key = key_nxt;
      fin_lbl = lbl_nxt;
    end else begin
      fin_ok = ok_r;
      fin_v6 = v6_r;
      fin_key = key_r;
      fin_lbl = lbl_r;
    end
  end

  assign job_valid = in_valid && in_last_byte;
  assign job.drop = !fin_ok;
  assign job.ipv6 = fin_v6;
  assign job.key = fin_key;
  assign job.labels = fin_lbl;
endmodule

// File: sv/pwc_queue.sv
// Small job queue between parser and worker selector.
module pwc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  pwc_pkg::job_t wr_job,
  output logic          rd_valid,
  input  logic          rd_ready,
  output pwc_pkg::job_t rd_job
);
  import pwc_pkg::*;
  localparam int PW = $clog2(QDepth);
  job_t mem_r [QDepth];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0] cnt_r;
  logic wr, rd;
  assign wr_ready = cnt_r != (PW+1)'(QDepth);
  assign rd_valid = cnt_r != '0;
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_job = mem_r[rp_r];
  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_job;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == PW'(QDepth - 1)) ? '0 : wp_r + 1'b1;
      if (rd) rp_r <= (rp_r == PW'(QDepth - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(wr) - (PW+1)'(rd);
    end
  end
`ifndef NO_ASSERTIONS
  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PW+1)'(QDepth)) else $error("queue overflow");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (wr && !rd) |=> cnt_r == $past(cnt_r) + 1'b1) else $error("count slip");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> !rd) else $error("read when empty");
`endif
endmodule

// File: sv/pwc_selector.sv
// Back end: worker selection by mask or serial modulo, output register.
module pwc_selector (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  output logic          job_ready,
  input  pwc_pkg::job_t job,
  input  logic [6:0]    worker_count,
  input  logic          mpls_strip_enable,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_worker_port,
  output logic          out_drop,
  output logic [5:0]    out_strip_length
);
  import pwc_pkg::*;
  typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} st_t;
  st_t st_r;
  logic [31:0] q_r;
  logic [6:0] rem_r;
  logic [5:0] cnt_r;
  logic v6_r;
  logic [LblW-1:0] lbl_r;
  logic [7:0] rem_sh;
  logic [7:0] port_nxt;
  logic pow2;

  assign pow2 = (worker_count & (worker_count - 7'd1)) == 7'd0;
  assign rem_sh = {rem_r, q_r[31]};
  assign job_ready = st_r == S_IDLE;
  assign port_nxt = {1'b0, rem_r} + (v6_r ? {1'b0, worker_count} : 8'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: if (job_valid) begin
          v6_r <= job.ipv6;
          lbl_r <= job.labels;
          q_r <= job.key;
          rem_r <= 7'd0;
          cnt_r <= 6'd0;
          if (job.drop || worker_count == 7'd0) begin
            out_valid <= 1'b1; out_drop <= 1'b1;
            out_worker_port <= 8'd0; out_strip_length <= 6'd0;
            st_r <= S_OUT;
          end else if (pow2) begin
            rem_r <= job.key[6:0] & (worker_count - 7'd1);
            cnt_r <= 6'd32;
            st_r <= S_DIV;
          end else st_r <= S_DIV;
        end
        S_DIV: begin
          if (cnt_r == 6'd32) begin
            out_valid <= 1'b1; out_drop <= 1'b0;
            out_worker_port <= port_nxt;
            out_strip_length <= (mpls_strip_enable && lbl_r != '0)
              ? 6'({lbl_r, 2'b00}) : 6'd0;
            st_r <= S_OUT;
          end else begin
            // restoring remainder, one key bit per cycle
            rem_r <= (rem_sh >= {1'b0, worker_count}) ?
              7'(rem_sh - {1'b0, worker_count}) : rem_sh[6:0];
            q_r <= {q_r[30:0], 1'b0};
            cnt_r <= cnt_r + 6'd1;
          end
        end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_worker_port))
    else $error("output not held");
  a_drop0: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_drop) |-> out_worker_port == 8'd0 && out_strip_length == 6'd0)
    else $error("drop with payload");
  a_vld: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> st_r == S_OUT) else $error("valid outside output state");
`endif
endmodule

// File: sv/packet_worker_classifier_unit.sv
// Top level of the packet worker classifier: parser, job queue, selector, config.
// Header bytes transfer at one per cycle while the queue has room; the parser
// decides each packet on the fly and pushes one job into a two-entry queue on the
// last byte. The selector then sends a dropped packet straight to output, masks
// the key when worker_count is a power of two, or runs a 32-step serial remainder
// otherwise, before the output transfer. Config registers at byte addresses
// 0,4,8,12: worker_count, qinq_ethertype, ipv6_key_byte_offset, mpls_strip_enable;
// they must be written only while idle, by the user; the block does not enforce it.
module packet_worker_classifier_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_worker_port,
  output logic        out_drop,
  output logic [5:0]  out_strip_length,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import pwc_pkg::*;

  logic [6:0]  wc_r;
  logic [15:0] qe_r;
  logic [5:0]  v6o_r;
  logic        se_r;

  job_t pj, qj;
  logic pv, pr, qv, qr;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r <= 7'd1; qe_r <= 16'h8100; v6o_r <= 6'd23; se_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[3:2])
        AddrWorkerCount: wc_r <= cfg_pwdata[6:0];
        AddrQinqEt:      qe_r <= cfg_pwdata[15:0];
        AddrIpv6Off:     v6o_r <= cfg_pwdata[5:0];
        AddrStripEn:     se_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      AddrWorkerCount: cfg_prdata = {25'd0, wc_r};
      AddrQinqEt:      cfg_prdata = {16'd0, qe_r};
      AddrIpv6Off:     cfg_prdata = {26'd0, v6o_r};
      AddrStripEn:     cfg_prdata = {31'd0, se_r};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  // last-byte transfer waits for queue room; other bytes too, keeping it simple
  pwc_parser u_parser (
    .clk, .rst_n, .in_valid, .in_ready, .in_data_byte, .in_last_byte,
    .qinq_ethertype(qe_r), .ipv6_key_byte_offset(v6o_r),
    .job_valid(pv), .job_ready(pr), .job(pj)
  );

  pwc_queue u_queue (
    .clk, .rst_n, .wr_valid(pv), .wr_ready(pr), .wr_job(pj),
    .rd_valid(qv), .rd_ready(qr), .rd_job(qj)
  );

  pwc_selector u_sel (
    .clk, .rst_n, .job_valid(qv), .job_ready(qr), .job(qj),
    .worker_count(wc_r), .mpls_strip_enable(se_r),
    .out_valid, .out_ready, .out_worker_port, .out_drop, .out_strip_length
  );
endmodule
